// ----- rtl/core/esc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the sensor compensation block.
package esc_pkg;

    localparam int QDEPTH = 8;
    localparam int QAW    = 3;
    localparam int NSTG   = 82;
    localparam int DIVN   = 64;

    localparam logic [2:0] CFG_TCAL = 3'd0;
    localparam logic [2:0] CFG_PA   = 3'd1;
    localparam logic [2:0] CFG_PB   = 3'd2;
    localparam logic [2:0] CFG_PC   = 3'd3;
    localparam logic [2:0] CFG_HCAL = 3'd4;

    localparam logic [1:0] ACT_TEMP = 2'd0;
    localparam logic [1:0] ACT_PRES = 2'd1;
    localparam logic [1:0] ACT_HUM  = 2'd2;

    localparam logic [63:0] PRES_T_OFS = 64'd128000;
    localparam logic [63:0] PRES_ONE47 = 64'h0000_8000_0000_0000;
    localparam logic [63:0] PRES_FULL  = 64'd1048576;
    localparam logic [63:0] PRES_SCALE = 64'd3125;
    localparam logic [31:0] HUM_T_OFS  = 32'd76800;
    localparam logic [31:0] HUM_MAX    = 32'd419430400;
    localparam logic [31:0] HUM_RND_A  = 32'd16384;
    localparam logic [31:0] HUM_OFS_D  = 32'd2097152;
    localparam logic [31:0] HUM_OFS_C  = 32'd32768;
    localparam logic [31:0] HUM_RND_E  = 32'd8192;
    localparam logic [31:0] TEMP_RND   = 32'd128;

    typedef struct packed {
        logic [1:0]  action;
        logic [19:0] raw_temperature;
        logic [19:0] raw_measurement;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic signed [31:0] fine_temp_out;
        logic               divide_by_zero;
    } t_out;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] fine;
        logic [19:0] raw;
    } t_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] fine;
        logic [19:0] raw;
        logic [31:0] aux;
        logic        dz;
    } t_tok;

    // Partial products of a 64x64 multiply that keeps the low 64 bits.
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] x;
    } t_mpart;

    function automatic t_mpart mul_part(input logic [63:0] a, input logic [63:0] b);
        t_mpart m;
        m.ll = 64'(a[31:0]) * 64'(b[31:0]);
        m.x  = 32'(a[31:0] * b[63:32]) + 32'(a[63:32] * b[31:0]);
        return m;
    endfunction

    function automatic logic [63:0] mul_sum(input t_mpart m);
        return m.ll + {m.x, 32'd0};
    endfunction

    function automatic logic [63:0] sx16_64(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx12_32(input logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

// ----- rtl/core/env_sensor_compensation.sv -----
// Top level of the temperature, pressure and humidity compensation block.
//
// Items enter through a queue-style port: a transaction is taken on a rising
// edge with push high and full low. Each item carries an action, a raw
// temperature reading and a raw pressure or humidity reading.
// Results leave through a queue-style port: the oldest result is shown while
// empty is low and is taken on a rising edge with pop high.
// Calibration words are written over a separate valid/ready channel that is
// always ready; writes are expected only while the block is idle.
// The front end forms the fine temperature, a short queue follows, and the
// back end is an 82-stage pipeline whose length is set by the 64-step
// radix-2 divider used for pressure. One item per cycle is sustained while
// the receiver keeps popping.
// When the receiver stops popping, the back end holds, the queue fills and
// full rises; items accepted before that are kept and delivered in order.
// Reset is synchronous and active low; it clears all calibration words to
// zero and empties the pipeline and the queue.
module env_sensor_compensation import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in         i_in_data,
    output logic        empty,
    input  logic        pop,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [47:0]  r_tcal, r_pa, r_pb, r_pc;
    logic [63:0]  r_hcal;
    logic         acc, f_valid, q_empty, q_pop;
    t_item        f_item, q_item;
    logic [1:0]   f_inflight;
    logic [QAW:0] q_count;

    assign o_cfg_ready = 1'b1;

    // Calibration registers; writes beyond the last index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_pc   <= '0;
            r_hcal <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TCAL: r_tcal <= i_cfg_data[47:0];
                CFG_PA:   r_pa   <= i_cfg_data[47:0];
                CFG_PB:   r_pb   <= i_cfg_data[47:0];
                CFG_PC:   r_pc   <= i_cfg_data[47:0];
                CFG_HCAL: r_hcal <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Items still inside the front end count against the queue space, so the
    // front end never has to stall.
    assign full = ((QAW+2)'(q_count) + (QAW+2)'(f_inflight)) >= (QAW+2)'(QDEPTH);
    assign acc  = push && !full;

    esc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_in       (i_in_data),
        .i_tcal     (r_tcal),
        .o_valid    (f_valid),
        .o_item     (f_item),
        .o_inflight (f_inflight)
    );

    esc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_item),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_item),
        .o_count (q_count)
    );

    esc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_item    (q_item),
        .o_q_pop   (q_pop),
        .i_pcal_a  (r_pa),
        .i_pcal_b  (r_pb),
        .i_pcal_c  (r_pc),
        .i_hcal    (r_hcal),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out     (o_out_data)
    );

endmodule

// ----- rtl/core/esc_front.sv -----
// Front end: accepts items and works out the fine temperature in three stages.
module esc_front import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  t_in         i_in,
    input  logic [47:0] i_tcal,
    output logic        o_valid,
    output t_item       o_item,
    output logic [1:0]  o_inflight
);

    logic [15:0] t1;
    logic [31:0] t2, t3, dx, dd;
    logic [2:0]  r_vld;
    logic [31:0] r_ma, r_dd, r_a, r_bm, r_fine;
    logic [1:0]  r_act [3];
    logic [19:0] r_raw [3];

    assign t1 = i_tcal[15:0];
    assign t2 = sx16_32(i_tcal[31:16]);
    assign t3 = sx16_32(i_tcal[47:32]);
    assign dx = {15'd0, i_in.raw_temperature[19:3]} - {15'd0, t1, 1'b0};
    assign dd = {16'd0, i_in.raw_temperature[19:4]} - {16'd0, t1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma     <= dx * t2;
        r_dd     <= dd * dd;
        r_act[0] <= i_in.action;
        r_raw[0] <= i_in.raw_measurement;
        r_a      <= 32'($signed(r_ma) >>> 11);
        r_bm     <= 32'($signed(r_dd) >>> 12) * t3;
        r_act[1] <= r_act[0];
        r_raw[1] <= r_raw[0];
        r_fine   <= r_a + 32'($signed(r_bm) >>> 14);
        r_act[2] <= r_act[1];
        r_raw[2] <= r_raw[1];
    end

    assign o_valid     = r_vld[2];
    assign o_item      = '{action: r_act[2], fine: r_fine, raw: r_raw[2]};
    assign o_inflight  = {1'b0, r_vld[0]} + {1'b0, r_vld[1]} + {1'b0, r_vld[2]};

endmodule

// ----- rtl/core/esc_queue.sv -----
// Short queue that decouples the front end from the compute back end.
module esc_queue import esc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_item        i_data,
    input  logic         i_pop,
    output logic         o_empty,
    output t_item        o_data,
    output logic [QAW:0] o_count
);

    t_item           r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp, r_rp;
    logic [QAW:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

// ----- rtl/core/esc_back.sv -----
// Back end: pressure, humidity and temperature pipelines with a radix-2 divider.
module esc_back import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_item,
    output logic        o_q_pop,
    input  logic [47:0] i_pcal_a,
    input  logic [47:0] i_pcal_b,
    input  logic [47:0] i_pcal_c,
    input  logic [63:0] i_hcal,
    output logic        o_empty,
    input  logic        i_pop,
    output t_out        o_out
);

    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic        ce, take;
    logic [31:0] tmul, h_ain, hx2, hcl;
    logic [63:0] q, pres;
    t_tok        n_tok8, n_tok75;

    logic [NSTG-1:0] r_vld;
    t_tok            r_tok [NSTG];

    logic [63:0] r_v1, r_sq, r_m5, r_m2, r_m5_3, r_m2_3, r_a6, r_a3, r_m5_4, r_m2_4;
    t_mpart      r_sqp, r_m5p, r_m2p, r_a6p, r_a3p, r_c1p, r_pnp;
    logic [63:0] r_v2, r_v1b, r_t, r_pre, r_c1, r_pn, r_den, r_num;
    logic [63:0] r_rem [DIVN+1];
    logic [63:0] r_quo [DIVN+1];
    logic [63:0] r_ad  [DIVN+1];
    logic        r_neg [DIVN+1];
    logic        r_dz  [DIVN+1];
    logic [63:0] n_rem [DIVN];
    logic [DIVN-1:0] n_ge;
    logic [63:0] r_p, r_p76, r_q76, r_m9a, r_m8, r_p77, r_q77, r_m8_78, r_p78;
    logic [63:0] r_m9, r_m8_79, r_p79, r_s;
    t_mpart      r_m9p, r_m8p, r_m9p2;
    logic [31:0] r_res;
    logic [31:0] r_hx, r_hm5, r_hm6, r_hm3, r_ha, r_hb, r_hc, r_ha3, r_hbc;
    logic [31:0] r_ha4, r_hdh, r_hae, r_hae6, r_hss, r_hae7, r_ht;

    assign p1 = {48'd0, i_pcal_a[15:0]};
    assign p2 = sx16_64(i_pcal_a[31:16]);
    assign p3 = sx16_64(i_pcal_a[47:32]);
    assign p4 = sx16_64(i_pcal_b[15:0]);
    assign p5 = sx16_64(i_pcal_b[31:16]);
    assign p6 = sx16_64(i_pcal_b[47:32]);
    assign p7 = sx16_64(i_pcal_c[15:0]);
    assign p8 = sx16_64(i_pcal_c[31:16]);
    assign p9 = sx16_64(i_pcal_c[47:32]);
    assign h1 = {24'd0, i_hcal[7:0]};
    assign h2 = sx16_32(i_hcal[23:8]);
    assign h3 = {24'd0, i_hcal[31:24]};
    assign h4 = sx12_32(i_hcal[43:32]);
    assign h5 = sx12_32(i_hcal[55:44]);
    assign h6 = sx8_32(i_hcal[63:56]);

    // The whole pipe moves together; it holds only while a result waits unread.
    assign ce      = !r_vld[NSTG-1] || i_pop;
    assign take    = ce && !i_q_empty;
    assign o_q_pop = take;

    assign tmul  = (i_item.fine << 2) + i_item.fine + TEMP_RND;
    assign h_ain = {2'd0, r_tok[1].raw[15:0], 14'd0} - (h4 << 20) - r_hm5 + HUM_RND_A;
    assign hx2   = r_hae7 - 32'($signed(r_ht) >>> 4);
    assign hcl   = hx2[31] ? 32'd0 : ((hx2 > HUM_MAX) ? HUM_MAX : hx2);
    assign q     = 64'($signed(r_p) >>> 13);
    assign pres  = 64'($signed(r_s) >>> 8) + (p7 << 4);

    // One restoring step of the unsigned divider per stage.
    always_comb begin
        for (int k = 0; k < DIVN; k++) begin
            n_ge[k]  = ({r_rem[k], r_quo[k][63]} >= {1'b0, r_ad[k]});
            n_rem[k] = n_ge[k] ? 64'({r_rem[k], r_quo[k][63]} - {1'b0, r_ad[k]})
                               : {r_rem[k][62:0], r_quo[k][63]};
        end
    end

    // Tokens that pick up the humidity result and the divide-by-zero flag.
    always_comb begin
        n_tok8 = r_tok[7];
        if (r_tok[7].action == ACT_HUM) begin
            n_tok8.aux = hcl >> 12;
        end else if (r_tok[7].action != ACT_TEMP) begin
            n_tok8.aux = 32'd0;
        end
        n_tok75    = r_tok[74];
        n_tok75.dz = r_dz[DIVN] && (r_tok[74].action == ACT_PRES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[NSTG-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_tok[0] <= '{action: i_item.action, fine: i_item.fine, raw: i_item.raw,
                          aux: 32'($signed(tmul) >>> 8), dz: 1'b0};
            for (int i = 1; i < NSTG; i++) begin
                if (i == 8) begin
                    r_tok[i] <= n_tok8;
                end else if (i == 75) begin
                    r_tok[i] <= n_tok75;
                end else begin
                    r_tok[i] <= r_tok[i-1];
                end
            end
            r_v1  <= {{32{i_item.fine[31]}}, i_item.fine} - PRES_T_OFS;
            r_sqp <= mul_part(r_v1, r_v1);
            r_m5p <= mul_part(r_v1, p5);
            r_m2p <= mul_part(r_v1, p2);
            r_sq  <= mul_sum(r_sqp);
            r_m5  <= mul_sum(r_m5p);
            r_m2  <= mul_sum(r_m2p);
            r_a6p <= mul_part(r_sq, p6);
            r_a3p <= mul_part(r_sq, p3);
            r_m5_3 <= r_m5;
            r_m2_3 <= r_m2;
            r_a6  <= mul_sum(r_a6p);
            r_a3  <= mul_sum(r_a3p);
            r_m5_4 <= r_m5_3;
            r_m2_4 <= r_m2_3;
            r_v2  <= r_a6 + (r_m5_4 << 17) + (p4 << 35);
            r_v1b <= 64'($signed(r_a3) >>> 8) + (r_m2_4 << 12);
            r_t   <= PRES_ONE47 + r_v1b;
            r_pre <= ((PRES_FULL - 64'(r_tok[5].raw)) << 31) - r_v2;
            r_c1p <= mul_part(r_t, p1);
            r_pnp <= mul_part(r_pre, PRES_SCALE);
            r_c1  <= mul_sum(r_c1p);
            r_pn  <= mul_sum(r_pnp);
            r_den <= 64'($signed(r_c1) >>> 33);
            r_num <= r_pn;
            // Divide magnitudes, then restore the sign; truncates toward zero.
            r_rem[0] <= '0;
            r_quo[0] <= r_num[63] ? (64'd0 - r_num) : r_num;
            r_ad[0]  <= r_den[63] ? (64'd0 - r_den) : r_den;
            r_neg[0] <= r_num[63] ^ r_den[63];
            r_dz[0]  <= (r_den == '0);
            for (int k = 0; k < DIVN; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_quo[k+1] <= {r_quo[k][62:0], n_ge[k]};
                r_ad[k+1]  <= r_ad[k];
                r_neg[k+1] <= r_neg[k];
                r_dz[k+1]  <= r_dz[k];
            end
            r_p <= r_dz[DIVN] ? 64'd0
                 : (r_neg[DIVN] ? (64'd0 - r_quo[DIVN]) : r_quo[DIVN]);
            r_m9p   <= mul_part(p9, q);
            r_m8p   <= mul_part(p8, r_p);
            r_p76   <= r_p;
            r_q76   <= q;
            r_m9a   <= mul_sum(r_m9p);
            r_m8    <= mul_sum(r_m8p);
            r_p77   <= r_p76;
            r_q77   <= r_q76;
            r_m9p2  <= mul_part(r_m9a, r_q77);
            r_m8_78 <= r_m8;
            r_p78   <= r_p77;
            r_m9    <= mul_sum(r_m9p2);
            r_m8_79 <= r_m8_78;
            r_p79   <= r_p78;
            r_s     <= r_p79 + 64'($signed(r_m9) >>> 25) + 64'($signed(r_m8_79) >>> 19);
            if (r_tok[80].action == ACT_PRES) begin
                r_res <= r_tok[80].dz ? 32'd0 : pres[31:0];
            end else begin
                r_res <= r_tok[80].aux;
            end

            // Humidity runs alongside the pressure front stages.
            r_hx   <= i_item.fine - HUM_T_OFS;
            r_hm5  <= h5 * r_hx;
            r_hm6  <= r_hx * h6;
            r_hm3  <= r_hx * h3;
            r_ha   <= 32'($signed(h_ain) >>> 15);
            r_hb   <= 32'($signed(r_hm6) >>> 10);
            r_hc   <= 32'($signed(r_hm3) >>> 11) + HUM_OFS_C;
            r_ha3  <= r_ha;
            r_hbc  <= r_hb * r_hc;
            r_ha4  <= r_ha3;
            r_hdh  <= (32'($signed(r_hbc) >>> 10) + HUM_OFS_D) * h2;
            r_hae  <= r_ha4 * 32'($signed(r_hdh + HUM_RND_E) >>> 14);
            r_hae6 <= r_hae;
            r_hss  <= 32'($signed(r_hae) >>> 15) * 32'($signed(r_hae) >>> 15);
            r_hae7 <= r_hae6;
            r_ht   <= 32'($signed(r_hss) >>> 7) * h1;
        end
    end

    assign o_empty              = !r_vld[NSTG-1];
    assign o_out.result_value   = r_res;
    assign o_out.fine_temp_out  = r_tok[NSTG-1].fine;
    assign o_out.divide_by_zero = r_tok[NSTG-1].dz;

endmodule

// ----- tb/sv/tb_env_sensor_compensation.sv -----
// Self-checking testbench for the temperature, pressure and humidity compensation block.
`timescale 1ns / 100ps

module tb_env_sensor_compensation;
    import esc_pkg::*;

    // Clock and the single reset at the start of the run.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in         i_in_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    always #4 i_clk = ~i_clk;

    env_sensor_compensation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_data  (i_in_data),
        .empty      (empty),
        .pop        (pop),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // The predictor keeps its own copy of the calibration words and of the
    // fine temperature register.
    logic [47:0] cal_t, cal_pa, cal_pb, cal_pc;
    logic [63:0] cal_h;
    logic [31:0] fine_reg;

    t_out        pending_results[$];
    int          error_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          dz_seen = 0;
    int          settings_used = 0;

    // Each directed row carries an optional hand-typed expectation.
    typedef struct {
        t_in  item;
        logic fixed;
        t_out want;
    } t_row;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] fine_temperature_of(input logic [19:0] adc);
        logic [31:0] t1, t2, t3, a, d, b, adc32;
        adc32 = {12'd0, adc};
        t1 = {16'd0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        a = asr32(((adc32 >> 3) - (t1 << 1)) * t2, 11);
        d = (adc32 >> 4) - t1;
        b = asr32(asr32(d * d, 12) * t3, 14);
        return a + b;
    endfunction

    function automatic logic signed [63:0] trunc_div(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        if (a == 64'sh8000_0000_0000_0000 && b == -64'sd1)
            return a;
        return a / b;
    endfunction

    function automatic logic [31:0] pressure_of(input logic [19:0] adc, output logic dz);
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q;
        p1 = {48'd0, cal_pa[15:0]};
        p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
        p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
        p4 = {{48{cal_pb[15]}}, cal_pb[15:0]};
        p5 = {{48{cal_pb[31]}}, cal_pb[31:16]};
        p6 = {{48{cal_pb[47]}}, cal_pb[47:32]};
        p7 = {{48{cal_pc[15]}}, cal_pc[15:0]};
        p8 = {{48{cal_pc[31]}}, cal_pc[31:16]};
        p9 = {{48{cal_pc[47]}}, cal_pc[47:32]};
        dz = 1'b0;
        v1 = {{32{fine_reg[31]}}, fine_reg} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0) begin
            dz = 1'b1;
            return 32'd0;
        end
        p = 64'd1048576 - {44'd0, adc};
        p = ((p << 31) - v2) * 64'd3125;
        p = trunc_div(p, v1);
        q = asr64(p, 13);
        v1 = asr64(p9 * q * q, 25);
        v2 = asr64(p8 * p, 19);
        p = asr64(p + v1 + v2, 8) + (p7 << 4);
        return p[31:0];
    endfunction

    function automatic logic [31:0] humidity_of(input logic [15:0] adc);
        logic [31:0] h1, h2, h3, h4, h5, h6, x, a, b, c, d, e, s;
        h1 = {24'd0, cal_h[7:0]};
        h2 = {{16{cal_h[23]}}, cal_h[23:8]};
        h3 = {24'd0, cal_h[31:24]};
        h4 = {{20{cal_h[43]}}, cal_h[43:32]};
        h5 = {{20{cal_h[55]}}, cal_h[55:44]};
        h6 = {{24{cal_h[63]}}, cal_h[63:56]};
        x = fine_reg - 32'd76800;
        a = asr32(({16'd0, adc} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
        b = asr32(x * h6, 10);
        c = asr32(x * h3, 11) + 32'd32768;
        d = asr32(b * c, 10) + 32'd2097152;
        e = asr32(d * h2 + 32'd8192, 14);
        x = a * e;
        s = asr32(x, 15);
        x = x - asr32(asr32(s * s, 7) * h1, 4);
        if (x[31])
            x = 32'd0;
        if (x > 32'd419430400)
            x = 32'd419430400;
        return x >> 12;
    endfunction

    // Computes the compensated result of one item and advances the fine
    // temperature register, as the block does on every accepted item.
    function automatic t_out compensate(input t_in it);
        t_out r;
        logic dz;
        r = '0;
        fine_reg = fine_temperature_of(it.raw_temperature);
        r.fine_temp_out = fine_reg;
        case (it.action)
            ACT_TEMP: r.result_value = asr32(fine_reg * 32'd5 + 32'd128, 8);
            ACT_PRES: begin
                r.result_value = pressure_of(it.raw_measurement, dz);
                r.divide_by_zero = dz;
            end
            ACT_HUM:  r.result_value = humidity_of(it.raw_measurement[15:0]);
            default:  r.result_value = '0;
        endcase
        return r;
    endfunction

    // Calibration writes happen only while the pipeline is drained.
    task automatic write_cal(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TCAL: cal_t  = val[47:0];
            CFG_PA:   cal_pa = val[47:0];
            CFG_PB:   cal_pb = val[47:0];
            CFG_PC:   cal_pc = val[47:0];
            CFG_HCAL: cal_h  = val;
            default: ;
        endcase
    endtask

    task automatic write_all_cal(input logic [63:0] t, input logic [63:0] pa,
                                 input logic [63:0] pb, input logic [63:0] pc,
                                 input logic [63:0] h);
        write_cal(CFG_TCAL, t);
        write_cal(CFG_PA, pa);
        write_cal(CFG_PB, pb);
        write_cal(CFG_PC, pc);
        write_cal(CFG_HCAL, h);
        settings_used++;
    endtask

    // Sends one item after a random gap; the expectation is queued at the
    // edge where the transaction is taken. With no gap, push stays high so
    // that items follow back to back.
    task automatic send_item(input t_in it, input logic fixed, input t_out want);
        t_out predicted;
        int   gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (full);
        predicted = compensate(it);
        if (fixed && predicted != want)
            report_mismatch("directed row vs predictor", predicted.result_value,
                            want.result_value);
        pending_results.push_back(fixed ? want : predicted);
        items_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic t_in random_item();
        t_in it;
        it.action = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        it.raw_temperature = 20'($urandom);
        it.raw_measurement = 20'($urandom);
        // Keep most readings near a realistic operating range.
        if ($urandom_range(0, 3) != 0) begin
            it.raw_temperature = 20'd480000 + 20'($urandom_range(0, 100000));
            if (it.action == ACT_PRES)
                it.raw_measurement = 20'd300000 + 20'($urandom_range(0, 150000));
        end
        return it;
    endfunction

    // The receiver pops with a random stall after each result and checks every
    // result against the oldest expectation.
    initial begin : result_checker
        t_out want;
        int   stall;
        stall = $urandom_range(0, 4);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected", o_out_data.result_value, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.result_value !== want.result_value)
                        report_mismatch("result_value", o_out_data.result_value,
                                        want.result_value);
                    if (o_out_data.fine_temp_out !== want.fine_temp_out)
                        report_mismatch("fine_temp_out", o_out_data.fine_temp_out,
                                        want.fine_temp_out);
                    if (o_out_data.divide_by_zero !== want.divide_by_zero)
                        report_mismatch("divide_by_zero", 32'(o_out_data.divide_by_zero),
                                        32'(want.divide_by_zero));
                    if (want.divide_by_zero)
                        dz_seen++;
                end
                results_seen++;
                stall = $urandom_range(0, 4);
                if (stall != 0)
                    pop <= 1'b0;
            end else if (!pop) begin
                if (stall > 0)
                    stall--;
                if (stall == 0)
                    pop <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_row rows[$];
        t_row r;
        t_out none;
        none = '0;
        cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_h = '0;
        fine_reg = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With all calibration at zero the fine temperature is zero and the
        // pressure divisor is zero.
        r.item = '{ACT_TEMP, 20'hFFFFF, 20'h00000}; r.fixed = 1;
        r.want = '{32'sd0, 32'sd0, 1'b0}; rows.push_back(r);
        r.item = '{ACT_PRES, 20'h00000, 20'hFFFFF}; r.fixed = 1;
        r.want = '{32'sd0, 32'sd0, 1'b1}; rows.push_back(r);
        r.item = '{ACT_PRES, 20'hFFFFF, 20'h00000}; r.fixed = 1;
        r.want = '{32'sd0, 32'sd0, 1'b1}; rows.push_back(r);
        r.item = '{2'd3, 20'h12345, 20'hFFFFF}; r.fixed = 1;
        r.want = '{32'sd0, 32'sd0, 1'b0}; rows.push_back(r);
        r.item = '{ACT_HUM, 20'h00000, 20'hFFFFF}; r.fixed = 0; r.want = none;
        rows.push_back(r);
        foreach (rows[i])
            send_item(rows[i].item, rows[i].fixed, rows[i].want);
        wait_drained();
        rows.delete();

        // Typical datasheet calibration.
        write_all_cal({16'sd50, 16'sd26435, 16'd27504},
                      {-16'sd3024, -16'sd10685, 16'd36477},
                      {-16'sd7, 16'sd140, 16'sd2855},
                      {16'sd6000, -16'sd14600, 16'sd15500},
                      {8'sd30, 12'sd50, 12'sd320, 8'd0, 16'sd360, 8'd75});
        r.fixed = 0; r.want = none;
        r.item = '{ACT_TEMP, 20'd519888, 20'd415148}; rows.push_back(r);
        r.item = '{ACT_PRES, 20'd519888, 20'd415148}; rows.push_back(r);
        r.item = '{ACT_HUM, 20'd519888, 20'd30000}; rows.push_back(r);
        r.item = '{ACT_HUM, 20'd519888, 20'hF0000}; rows.push_back(r);
        r.item = '{ACT_HUM, 20'd519888, 20'h0FFFF}; rows.push_back(r);
        r.item = '{ACT_HUM, 20'd519888, 20'h00000}; rows.push_back(r);
        r.item = '{ACT_PRES, 20'h00000, 20'h00000}; rows.push_back(r);
        r.item = '{ACT_PRES, 20'hFFFFF, 20'hFFFFF}; rows.push_back(r);
        r.item = '{ACT_TEMP, 20'hFFFFF, 20'h00000}; rows.push_back(r);
        r.item = '{ACT_TEMP, 20'h00000, 20'h00000}; rows.push_back(r);
        r.item = '{2'd3, 20'd519888, 20'd415148}; rows.push_back(r);
        foreach (rows[i])
            send_item(rows[i].item, rows[i].fixed, rows[i].want);
        wait_drained();

        // All-ones calibration, then random calibration sets.
        write_all_cal('1, '1, '1, '1, '1);
        for (int k = 0; k < 20; k++)
            send_item(random_item(), 1'b0, none);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase % 2 == 0)
                write_all_cal({$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom});
            else
                write_all_cal({16'($urandom_range(0, 100)), 16'($urandom_range(20000, 30000)),
                               16'($urandom_range(20000, 35000))},
                              {-16'sd3024, -16'sd10685, 16'($urandom)},
                              {-16'sd7, 16'($urandom), 16'sd2855},
                              {16'($urandom), -16'sd14600, 16'($urandom)},
                              {$urandom, $urandom});
            for (int k = 0; k < 110; k++)
                send_item(random_item(), 1'b0, none);
            wait_drained();
        end

        $display("Covered %0d items and %0d results over %0d calibration settings,",
                 items_sent, results_seen, settings_used);
        $display("with %0d zero-divisor pressure results.", dz_seen);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
